### hdl/ptw_pkg.sv
// Package for the four-level page-table walker: sizes, entry bits, opcodes,
// status codes, controller states and the structs passed between modules.
// Depends on nothing.
package ptw_pkg;

  localparam int NUM_TABLES = 16;
  localparam int VA_BITS    = 48;
  localparam int FRAME_BITS = 40;

  localparam int TBL_W  = $clog2(NUM_TABLES);
  localparam int IDX_W  = 9;
  localparam int ADDR_W = TBL_W + IDX_W;
  localparam int DEPTH  = NUM_TABLES * 512;

  localparam logic [63:0] PTE_P   = 64'h1;
  localparam logic [63:0] PTE_W   = 64'h2;
  localparam logic [63:0] PTE_U   = 64'h4;
  localparam logic [63:0] PTE_A   = 64'h20;
  localparam logic [63:0] PTE_D   = 64'h40;
  localparam logic [63:0] PTE_UWP = PTE_U | PTE_W | PTE_P;

  typedef enum logic [2:0] {
    OP_LOOKUP   = 3'd0,
    OP_MAP      = 3'd1,
    OP_CLEAR_P  = 3'd2,
    OP_QUERY_D  = 3'd3,
    OP_WRITE_D  = 3'd4,
    OP_QUERY_A  = 3'd5,
    OP_WRITE_A  = 3'd6,
    OP_NEW_ROOT = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_CLEAR,
    S_ROLLBACK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  root_table;
    logic [47:0] virt_addr;
    logic [39:0] phys_frame;
    logic        flag_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [51:0] phys_addr;
    logic        bit_value;
    logic        invalidate;
    logic [47:0] invalidate_page;
    logic [3:0]  new_table;
  } res_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
  } mem_req_t;

endpackage

### hdl/ptw_if.sv
// Handshake interfaces for the request and result channels of the walker.
// Depends on nothing.
interface ptw_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  root_table;
  logic [47:0] virt_addr;
  logic [39:0] phys_frame;
  logic        flag_value;
  modport source (output valid, opcode, root_table, virt_addr, phys_frame, flag_value,
                  input ready);
  modport sink   (input valid, opcode, root_table, virt_addr, phys_frame, flag_value,
                  output ready);
endinterface

interface ptw_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [51:0] phys_addr;
  logic        bit_value;
  logic        invalidate;
  logic [47:0] invalidate_page;
  logic [3:0]  new_table;
  modport source (output valid, status, phys_addr, bit_value, invalidate, invalidate_page,
                  new_table, input ready);
  modport sink   (input valid, status, phys_addr, bit_value, invalidate, invalidate_page,
                  new_table, output ready);
endinterface

### hdl/ptw_mem.sv
// Table store: single-port synchronous RAM holding all page tables.
// Depends on ptw_pkg.
module ptw_mem (
  input  logic              clk,
  input  ptw_pkg::mem_req_t mreq,
  output logic [63:0]       rdata
);
  import ptw_pkg::*;

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.addr] <= mreq.wdata;
    end
    if (mreq.re) begin
      rdata <= mem[mreq.addr];
    end
  end

endmodule

### hdl/ptw_ctrl.sv
// Walk sequencer: reads, modifies and writes entries of the table store,
// allocates, zeroes and frees tables. Depends on ptw_pkg.
module ptw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ptw_pkg::req_t     req,
  input  logic [4:0]        active_root,
  input  logic              res_free,
  input  logic [63:0]       mem_rdata,
  output logic              idle,
  output logic              done,
  output ptw_pkg::res_t     res,
  output ptw_pkg::mem_req_t mreq
);
  import ptw_pkg::*;

  state_t              state, state_next;
  req_t                cur, cur_next;
  res_t                res_next;
  logic [1:0]          lvl, lvl_next;
  logic [TBL_W-1:0]    tbl, tbl_next;
  logic [ADDR_W-1:0]   addr, addr_next;
  logic [NUM_TABLES-1:0] in_use, in_use_next;
  logic [TBL_W-1:0]    made [3];
  logic [TBL_W-1:0]    made_next [3];
  logic [ADDR_W-1:0]   where [3];
  logic [ADDR_W-1:0]   where_next [3];
  logic [1:0]          n, n_next;
  logic [IDX_W-1:0]    clr_cnt, clr_cnt_next;

  logic                free_found;
  logic [TBL_W-1:0]    free_id;
  logic [IDX_W-1:0]    idx;
  logic                present;
  logic                root_active;
  logic [63:0]         bitmask;

  // Lowest free table.
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = NUM_TABLES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_id    = TBL_W'(i);
      end
    end
  end

  always_comb begin
    unique case (lvl)
      2'd0:    idx = cur.virt_addr[47:39];
      2'd1:    idx = cur.virt_addr[38:30];
      2'd2:    idx = cur.virt_addr[29:21];
      default: idx = cur.virt_addr[20:12];
    endcase
  end

  assign present     = mem_rdata[0] && (mem_rdata[51:12] < 40'(NUM_TABLES));
  assign root_active = (active_root == {1'b0, cur.root_table});
  assign bitmask     = (cur.opcode == OP_QUERY_D || cur.opcode == OP_WRITE_D) ? PTE_D : PTE_A;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_use <= '0;
    end else begin
      state  <= state_next;
      in_use <= in_use_next;
    end
    cur     <= cur_next;
    res     <= res_next;
    lvl     <= lvl_next;
    tbl     <= tbl_next;
    addr    <= addr_next;
    made    <= made_next;
    where   <= where_next;
    n       <= n_next;
    clr_cnt <= clr_cnt_next;
  end

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    res_next     = res;
    lvl_next     = lvl;
    tbl_next     = tbl;
    addr_next    = addr;
    in_use_next  = in_use;
    made_next    = made;
    where_next   = where;
    n_next       = n;
    clr_cnt_next = clr_cnt;
    mreq         = '0;
    idle         = (state == S_IDLE);
    done         = (state == S_DONE);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cur_next        = req;
          res_next        = '0;
          res_next.status = ST_NONE;
          lvl_next        = '0;
          n_next          = '0;
          clr_cnt_next    = '0;
          if (req.opcode == OP_NEW_ROOT) begin
            if (free_found) begin
              in_use_next[free_id] = 1'b1;
              tbl_next             = free_id;
              res_next.status      = ST_OK;
              res_next.new_table   = 4'(free_id);
              state_next           = S_CLEAR;
            end else begin
              res_next.status = ST_FULL;
              state_next      = S_DONE;
            end
          end else if (32'(req.root_table) < NUM_TABLES) begin
            tbl_next   = TBL_W'(req.root_table);
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_READ: begin
        mreq.re    = 1'b1;
        mreq.addr  = {tbl, idx};
        addr_next  = {tbl, idx};
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (lvl != 2'd3) begin
          if (present) begin
            tbl_next   = mem_rdata[12 +: TBL_W];
            lvl_next   = lvl + 2'd1;
            state_next = S_READ;
          end else if (cur.opcode == OP_MAP) begin
            if (free_found) begin
              in_use_next[free_id] = 1'b1;
              made_next[n]         = free_id;
              where_next[n]        = addr;
              n_next               = n + 2'd1;
              mreq.we              = 1'b1;
              mreq.addr            = addr;
              mreq.wdata           = (64'(free_id) << 12) | PTE_UWP;
              tbl_next             = free_id;
              lvl_next             = lvl + 2'd1;
              clr_cnt_next         = '0;
              state_next           = S_CLEAR;
            end else begin
              res_next.status = ST_FULL;
              state_next      = S_ROLLBACK;
            end
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_DONE;
          case (cur.opcode)
            OP_LOOKUP: begin
              if (mem_rdata[0]) begin
                res_next.status    = ST_OK;
                res_next.phys_addr = {mem_rdata[51:12], cur.virt_addr[11:0]};
              end
            end
            OP_MAP: begin
              mreq.we         = 1'b1;
              mreq.addr       = addr;
              mreq.wdata      = (64'(cur.phys_frame[FRAME_BITS-1:0]) << 12) | PTE_U | PTE_P
                                | (cur.flag_value ? PTE_W : 64'h0);
              res_next.status = ST_OK;
            end
            OP_CLEAR_P: begin
              if (mem_rdata[0]) begin
                mreq.we             = 1'b1;
                mreq.addr           = addr;
                mreq.wdata          = mem_rdata & ~PTE_P;
                res_next.status     = ST_OK;
                res_next.invalidate = root_active;
              end
            end
            OP_QUERY_D, OP_QUERY_A: begin
              res_next.status    = ST_OK;
              res_next.bit_value = |(mem_rdata & bitmask);
            end
            OP_WRITE_D, OP_WRITE_A: begin
              mreq.we             = 1'b1;
              mreq.addr           = addr;
              mreq.wdata          = cur.flag_value ? (mem_rdata | bitmask)
                                                   : (mem_rdata & ~bitmask);
              res_next.status     = ST_OK;
              res_next.invalidate = root_active;
            end
            default: ;
          endcase
          res_next.invalidate_page = res_next.invalidate ? {cur.virt_addr[47:12], 12'h000}
                                                         : 48'h0;
        end
      end

      S_CLEAR: begin
        mreq.we      = 1'b1;
        mreq.addr    = {tbl, clr_cnt};
        mreq.wdata   = '0;
        clr_cnt_next = clr_cnt + IDX_W'(1);
        if (&clr_cnt) begin
          state_next = (cur.opcode == OP_NEW_ROOT) ? S_DONE : S_READ;
        end
      end

      S_ROLLBACK: begin
        if (n == 2'd0) begin
          state_next = S_DONE;
        end else begin
          n_next                     = n - 2'd1;
          in_use_next[made[n - 2'd1]] = 1'b0;
          mreq.we                    = 1'b1;
          mreq.addr                  = where[n - 2'd1];
          mreq.wdata                 = '0;
        end
      end

      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_one_port: assert property (@(posedge clk) disable iff (rst) !(mreq.re && mreq.we))
    else $error("table store read and written in one cycle");
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (mreq.we && mreq.wdata == 64'h0))
    else $error("clearing sweep writes non-zero data");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && idle) |=> (state != S_IDLE))
    else $error("accepted request did not start");
  a_rollback_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && lvl != 2'd3) |-> (n != 2'd3))
    else $error("more than three tables allocated by one request");

endmodule

### hdl/four_level_page_table_walker.sv
// Top level of the four-level page-table walker: handshake glue, result register
// and the active-root register. Depends on ptw_pkg, ptw_if, ptw_mem and ptw_ctrl.
//
// The walker keeps NUM_TABLES page tables of 512 64-bit entries in one single-port
// synchronous memory and serves one request at a time. Every table read has an
// address step and then an evaluate step, so a lookup, query or bit write starts,
// walks four table reads and then presents the result. Each table that has to be
// allocated, by a map or a new-root request, is zeroed by a sweep through all 512
// of its entries over the memory port, and a map that runs out of tables gives back
// each table it had allocated. The request side is ready whenever the sequencer is
// idle, even while the last result beat still waits to be taken. The active root may
// be written only while the walker is idle; it decides whether a write raises an
// invalidate.
module four_level_page_table_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  ptw_req_if.sink     req,
  ptw_rsp_if.source   rsp
);
  import ptw_pkg::*;

  logic       [4:0] active_root;
  req_t             req_beat;
  res_t             ctrl_res;
  res_t             out_res;
  mem_req_t         mreq;
  logic      [63:0] mem_rdata;
  logic             ctrl_idle;
  logic             ctrl_done;
  logic             res_free;
  logic             out_valid;

  // The root loaded in the translation base register; the reset value 16 matches no table.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_root <= 5'd16;
    end else if (cfg_we) begin
      active_root <= cfg_wdata;
    end
  end

  assign req_beat = '{opcode:     req.opcode,
                      root_table: req.root_table,
                      virt_addr:  req.virt_addr,
                      phys_frame: req.phys_frame,
                      flag_value: req.flag_value};
  assign req.ready = ctrl_idle;

  // The result register frees up in the same cycle as its beat is taken.
  assign res_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_done && res_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (ctrl_done && res_free) begin
      out_res <= ctrl_res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_res.status;
  assign rsp.phys_addr       = out_res.phys_addr;
  assign rsp.bit_value       = out_res.bit_value;
  assign rsp.invalidate      = out_res.invalidate;
  assign rsp.invalidate_page = out_res.invalidate_page;
  assign rsp.new_table       = out_res.new_table;

  ptw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (req.valid),
    .req         (req_beat),
    .active_root (active_root),
    .res_free    (res_free),
    .mem_rdata   (mem_rdata),
    .idle        (ctrl_idle),
    .done        (ctrl_done),
    .res         (ctrl_res),
    .mreq        (mreq)
  );

  ptw_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (mem_rdata)
  );

endmodule
